// ----- hw/rtl/xee_pkg.sv -----
// ----------------------------------------------------------------------------
// XML entity escaper package
// Shared types, character constants and run lookup functions.
// ----------------------------------------------------------------------------
package xee_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   typedef enum logic [2:0] {
      CLS_PLAIN,
      CLS_EOL,
      CLS_AMP,
      CLS_LT,
      CLS_GT,
      CLS_QUOT,
      CLS_APOS,
      CLS_BSL
   } cls_type;

   typedef struct packed {
      cls_type    cls;
      logic [7:0] data;
   } entry_type;

   localparam logic [7:0] CHR_AMP   = 8'h26;
   localparam logic [7:0] CHR_LT    = 8'h3C;
   localparam logic [7:0] CHR_GT    = 8'h3E;
   localparam logic [7:0] CHR_QUOT  = 8'h22;
   localparam logic [7:0] CHR_APOS  = 8'h27;
   localparam logic [7:0] CHR_BSL   = 8'h5C;
   localparam logic [7:0] CHR_CR    = 8'h0D;
   localparam logic [7:0] CHR_LF    = 8'h0A;
   localparam logic [7:0] CHR_UNDER = 8'h5F;

   // entity texts, left aligned in six bytes
   localparam logic [47:0] TXT_AMP  = {"&amp;", 8'h00};
   localparam logic [47:0] TXT_LT   = {"&lt;", 16'h0000};
   localparam logic [47:0] TXT_GT   = {"&gt;", 16'h0000};
   localparam logic [47:0] TXT_QUOT = "&quot;";
   localparam logic [47:0] TXT_APOS = {"&#39;", 8'h00};
   localparam logic [47:0] TXT_BSL  = {"&#92;", 8'h00};

   function automatic logic [2:0] run_len(input cls_type cls);
      logic [2:0] len;
      unique case (cls) inside
         CLS_PLAIN, CLS_EOL:            len = 3'd1;
         CLS_LT, CLS_GT:                len = 3'd4;
         CLS_AMP, CLS_APOS, CLS_BSL:    len = 3'd5;
         CLS_QUOT:                      len = 3'd6;
         default:                       len = 3'd1;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] run_byte(input entry_type ent, input logic [2:0] idx);
      logic [47:0] txt;
      logic [2:0]  sel;
      logic [7:0]  res;
      sel = 3'd5 - idx;
      txt = '0;
      res = ent.data;
      unique case (ent.cls)
         CLS_AMP:  txt = TXT_AMP;
         CLS_LT:   txt = TXT_LT;
         CLS_GT:   txt = TXT_GT;
         CLS_QUOT: txt = TXT_QUOT;
         CLS_APOS: txt = TXT_APOS;
         CLS_BSL:  txt = TXT_BSL;
         default:  txt = '0;
      endcase
      if (ent.cls == CLS_EOL) begin
         res = CHR_UNDER;
      end else if (ent.cls != CLS_PLAIN) begin
         res = txt[{sel, 3'b000} +: 8];
      end
      return res;
   endfunction

endpackage

// ----- hw/rtl/xml_entity_escaper_core.sv -----
// ----------------------------------------------------------------------------
// XML entity escaper core
// Byte stream escaper: markup characters to entities, CR/LF to underscore.
// ----------------------------------------------------------------------------
// One request byte is taken per cycle while req_stall is low and yields a run
// of one to six response bytes, one per cycle while rsp_stall is low, the last
// flagged by rsp_last_of_run. Plain bytes pass the front end input register,
// the queue and the output byte register; while an entity's run holds the
// response port, the front end keeps filling a QUEUE_DEPTH-entry queue and
// stalls requests only once that queue and its input register are full.
module xml_entity_escaper_core import xee_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_run
);

   logic      push, pop, full, head_valid;
   entry_type push_entry, head_entry;

   xee_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .push        (push),
      .push_entry  (push_entry),
      .queue_full  (full)
   );

   xee_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   xee_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_entry      (head_entry),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

// ----- hw/rtl/xee_front.sv -----
// ----------------------------------------------------------------------------
// XML entity escaper front end
// Accepts request bytes, classifies them and pushes entries to the queue.
// ----------------------------------------------------------------------------
module xee_front import xee_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       push,
   output entry_type  push_entry,
   input  logic       queue_full
);

   logic      valid_ff, valid_in;
   entry_type entry_ff, entry_in;
   logic      req_take;

   function automatic cls_type classify(input logic [7:0] b);
      cls_type c;
      unique case (b) inside
         CHR_AMP:          c = CLS_AMP;
         CHR_LT:           c = CLS_LT;
         CHR_GT:           c = CLS_GT;
         CHR_QUOT:         c = CLS_QUOT;
         CHR_APOS:         c = CLS_APOS;
         CHR_BSL:          c = CLS_BSL;
         CHR_CR, CHR_LF:   c = CLS_EOL;
         default:          c = CLS_PLAIN;
      endcase
      return c;
   endfunction

   assign push       = valid_ff && !queue_full;
   assign push_entry = entry_ff;
   assign req_stall  = valid_ff && queue_full;
   assign req_take   = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      if (push) begin
         valid_in = 1'b0;
      end
      if (req_take) begin
         valid_in      = 1'b1;
         entry_in.cls  = classify(req_in_byte);
         entry_in.data = req_in_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      entry_ff <= entry_in;
   end

endmodule

// ----- hw/rtl/xee_queue.sv -----
// ----------------------------------------------------------------------------
// XML entity escaper queue
// Small FIFO of classified entries between front and back ends.
// ----------------------------------------------------------------------------
module xee_queue import xee_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      head_valid,
   output entry_type head_entry
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   entry_type        mem [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == CNT_FULL);
   assign head_valid = (count_ff != '0);
   assign head_entry = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- hw/rtl/xee_back.sv -----
// ----------------------------------------------------------------------------
// XML entity escaper back end
// Expands the queue head into its byte run through a response register.
// ----------------------------------------------------------------------------
module xee_back import xee_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  entry_type  head_entry,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_run
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic [2:0] idx_ff, idx_in;
   logic       load;
   logic       at_last;

   assign load    = head_valid && (!valid_ff || !rsp_stall);
   assign at_last = (idx_ff == run_len(head_entry.cls) - 3'd1);
   assign pop     = load && at_last;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      idx_in   = idx_ff;
      if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
         byte_in  = run_byte(head_entry, idx_ff);
         last_in  = at_last;
         idx_in   = at_last ? 3'd0 : idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 3'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_last_of_run = last_ff;

endmodule

// ----- hw/rtl/xee_checker.sv -----
// ----------------------------------------------------------------------------
// XML entity escaper checker
// Port-level properties of the escaper core, bound to the top level.
// ----------------------------------------------------------------------------
module xee_checker import xee_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [7:0] req_in_byte,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last_of_run
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last_of_run))
      else $error("stalled response changed");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> $stable(req_in_byte) || !req_valid)
      else $error("stalled request changed");

   a_no_raw: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_out_byte != CHR_LT && rsp_out_byte != CHR_GT &&
         rsp_out_byte != CHR_QUOT && rsp_out_byte != CHR_APOS &&
         rsp_out_byte != CHR_BSL && rsp_out_byte != CHR_CR &&
         rsp_out_byte != CHR_LF)
      else $error("unescaped character on response");

   a_semi_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_byte == 8'h3B |-> rsp_last_of_run)
      else $error("entity terminator not last of run");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("not idle after reset");

endmodule

bind xml_entity_escaper_core xee_checker u_checker (.*);

// ----- verif/xml_entity_escaper_core_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// XML entity escaper core testbench
// Sends text bytes and checks each escaped response byte and its end-of-run
// flag against a run expander held in the bench. Covers the markup entities,
// CR/LF folding, byte extremes and random text with idle bursts on both sides.
// ----------------------------------------------------------------------------
module xml_entity_escaper_core_test;
   import xee_pkg::*;

   typedef struct {
      logic [7:0] data;
      logic       last;
   } esc_byte_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_in_byte;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_out_byte;
   logic       rsp_last_of_run;

   esc_byte_type escaped_q[$];
   int           mismatches;
   bit           idle_on;
   int           stall_left;

   xml_entity_escaper_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #400000;
      $display("FAILED: results differ");
      $finish;
   end

   // expected run for one accepted request byte
   function automatic void expand_byte(input logic [7:0] b);
      string txt;
      txt = "";
      case (b)
         CHR_AMP:  txt = "&amp;";
         CHR_LT:   txt = "&lt;";
         CHR_GT:   txt = "&gt;";
         CHR_QUOT: txt = "&quot;";
         CHR_APOS: txt = "&#39;";
         CHR_BSL:  txt = "&#92;";
         default:  txt = "";
      endcase
      if (b == CHR_CR || b == CHR_LF) begin
         escaped_q.push_back('{CHR_UNDER, 1'b1});
      end else if (txt.len() == 0) begin
         escaped_q.push_back('{b, 1'b1});
      end else begin
         for (int i = 0; i < txt.len(); i++) begin
            escaped_q.push_back('{txt[i], i == txt.len() - 1});
         end
      end
   endfunction

   function automatic logic [7:0] pick_markup();
      logic [7:0] b;
      case ($urandom_range(0, 7))
         0:       b = CHR_AMP;
         1:       b = CHR_LT;
         2:       b = CHR_GT;
         3:       b = CHR_QUOT;
         4:       b = CHR_APOS;
         5:       b = CHR_BSL;
         6:       b = CHR_CR;
         default: b = CHR_LF;
      endcase
      return b;
   endfunction

   // entered just after a rising edge; leaves valid high after acceptance
   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (req_stall);
      expand_byte(b);
   endtask

   // response side stall bursts
   always @(posedge clock) begin
      if (idle_on && stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 7);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall  <= 1'b0;
      end
   end

   always @(posedge clock) begin
      esc_byte_type exp_b;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (escaped_q.size() == 0) begin
            $error("unexpected response: out_byte %h last_of_run %b",
                   rsp_out_byte, rsp_last_of_run);
            mismatches++;
         end else begin
            exp_b = escaped_q.pop_front();
            if (rsp_out_byte !== exp_b.data) begin
               $error("out_byte: expected %h, actual %h", exp_b.data, rsp_out_byte);
               mismatches++;
            end
            if (rsp_last_of_run !== exp_b.last) begin
               $error("last_of_run: expected %b, actual %b",
                      exp_b.last, rsp_last_of_run);
               mismatches++;
            end
         end
      end
   end

   task automatic test_entities();
      send_byte(CHR_AMP);
      send_byte(CHR_LT);
      send_byte(CHR_GT);
      send_byte(CHR_QUOT);
      send_byte(CHR_APOS);
      send_byte(CHR_BSL);
      send_byte(CHR_CR);
      send_byte(CHR_LF);
      // entities back to back
      send_byte(CHR_QUOT);
      send_byte(CHR_QUOT);
      send_byte(CHR_LT);
      send_byte(CHR_AMP);
   endtask

   task automatic test_extremes();
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h7F);
      send_byte(8'h80);
      send_byte(8'h01);
      send_byte(8'hFE);
      send_byte(8'h55);
      send_byte(8'hAA);
      send_byte(8'h0B);
      send_byte(8'h0C);
      send_byte(8'h5D);
      send_byte(CHR_UNDER);
   endtask

   task automatic test_random_text(input int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 2) == 0) send_byte(pick_markup());
         else                           send_byte(8'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_in_byte = 8'h00;
      rsp_stall   = 1'b0;
      stall_left  = 0;
      mismatches  = 0;
      idle_on     = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_entities();
      test_extremes();
      test_random_text(66);
      // full rate streaming, no idling
      idle_on = 1'b0;
      test_random_text(30);

      req_valid <= 1'b0;
      while (escaped_q.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      if (mismatches == 0 && escaped_q.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
